[hdl/tmle_pkg.sv]
`timescale 1ns / 1ps

package tmle_pkg;

    localparam int CHK_W = 24;

    typedef enum logic [2:0] {
        MODE_TILE    = 3'd0,
        MODE_RGBA    = 3'd1,
        MODE_BLOCK   = 3'd2,
        MODE_TLUT    = 3'd3,
        MODE_RD_TILE = 3'd4,
        MODE_RD_RGBA = 3'd5,
        MODE_PHYS    = 3'd6,
        MODE_INVAL   = 3'd7
    } t_mode;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_BADREAD = 2'd2;
    localparam logic [1:0] ST_NOXFER  = 2'd3;

    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_FIRST_WORD = 3'd1;
    localparam logic [2:0] CFG_LINE_WORDS = 3'd2;
    localparam logic [2:0] CFG_ROW_LENGTH = 3'd3;
    localparam logic [2:0] CFG_ROW_COUNT  = 3'd4;
    localparam logic [2:0] CFG_DXT_STEP   = 3'd5;
    localparam logic [2:0] CFG_START_BYTE = 3'd6;

    localparam logic [1:0] CHK_WORK   = 2'd0;
    localparam logic [1:0] CHK_REJECT = 2'd1;
    localparam logic [1:0] CHK_EMPTY  = 2'd2;

    typedef struct packed {
        logic [7:0]  data_en;
        logic [63:0] data;
        logic        valid_we;
        logic [7:0]  valid;
        logic        stamp_we;
        logic [31:0] stamp;
    } t_store_wr;

    typedef struct packed {
        logic [63:0] data;
        logic [7:0]  valid;
        logic [31:0] stamp;
    } t_store_rd;

endpackage

[hdl/tmle_store.sv]
`timescale 1ns / 1ps

module tmle_store import tmle_pkg::*; #(
    parameter int WORDS = 512,
    parameter int SB = 32,
    localparam int AW = $clog2(WORDS)
) (
    input  logic            i_clk,
    input  logic [AW-1:0]   i_addr,
    input  t_store_wr       i_wr,
    output t_store_rd       o_rd
);

    logic [63:0]   r_data_mem  [WORDS];
    logic [7:0]    r_valid_mem [WORDS];
    logic [SB-1:0] r_stamp_mem [WORDS];

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 8; b++) begin
            if (i_wr.data_en[b]) begin
                r_data_mem[i_addr][8*b +: 8] <= i_wr.data[8*b +: 8];
            end
        end
        if (i_wr.valid_we) begin
            r_valid_mem[i_addr] <= i_wr.valid;
        end
        if (i_wr.stamp_we) begin
            r_stamp_mem[i_addr] <= i_wr.stamp[SB-1:0];
        end
        o_rd.data  <= r_data_mem[i_addr];
        o_rd.valid <= r_valid_mem[i_addr];
        o_rd.stamp <= 32'(r_stamp_mem[i_addr]);
    end

endmodule

[hdl/texture_memory_load_engine.sv]
`timescale 1ns / 1ps

// Texture memory load engine.
// Input channel (i_in_valid / o_in_ready) carries one word: opcode, payload,
// payload_bytes, query_word. Output channel (o_out_valid / i_out_ready)
// returns exactly one result word per input word, in order.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
// write it only while no input word is in flight. A write drops a transfer.
// One input word is worked at a time; o_in_ready is low while it runs.
// Each memory word touched takes a registered read (S_RD), then a write
// (S_WR) on the single port of the word store; setup and hand-off pass
// S_IDLE, S_SETUP and S_DONE. A start also runs the checks S_CHK1 and
// S_CHK2, and an accepted write start S_BUMP and S_GO; an invalidate then
// reads and writes each word of its byte range.
// After reset a clearing pass over every word zeroes all valid bits and
// stamps before o_in_ready rises; a generation wrap on a start runs such a
// pass over the stamps alone.
// The result sits in an output register; while the receiver stalls the next
// input word is still taken and worked, and it waits only to hand its own
// result into that register.

module texture_memory_load_engine import tmle_pkg::*; #(
    parameter int MEMORY_WORDS = 512,
    parameter int STAMP_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_payload,
    input  logic [3:0]  i_payload_bytes,
    input  logic [8:0]  i_query_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_read_data,
    output logic [3:0]  o_read_bytes,
    output logic        o_last_unit,
    output logic        o_word_is_valid,
    output logic [31:0] o_word_generation_out,
    output logic [31:0] o_current_generation
);

    localparam int AW = $clog2(MEMORY_WORDS);
    localparam logic [CHK_W-1:0] L_WORDS = CHK_W'(MEMORY_WORDS);
    localparam logic [CHK_W-1:0] L_HALF  = CHK_W'(MEMORY_WORDS / 2);
    localparam logic [CHK_W-1:0] L_BYTES = CHK_W'(MEMORY_WORDS * 8);
    localparam logic [AW-1:0] LAST_IDX = AW'(MEMORY_WORDS - 1);
    localparam logic [AW-1:0] HALF_IDX = AW'(MEMORY_WORDS / 2);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SETUP = 10'b0000000100,
        S_CHK1  = 10'b0000001000,
        S_CHK2  = 10'b0000010000,
        S_BUMP  = 10'b0000100000,
        S_GO    = 10'b0001000000,
        S_RD    = 10'b0010000000,
        S_WR    = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [9:0]  r_first, n_first, r_line, n_line;
    logic [12:0] r_rl, n_rl, r_rc, n_rc, r_sb, n_sb;
    logic [11:0] r_dxt, n_dxt;
    logic [STAMP_BITS-1:0] r_gen, n_gen;
    logic        r_active, n_active;
    logic [12:0] r_row, n_row, r_unit, n_unit;
    logic [23:0] r_acc, n_acc, r_row_base, n_row_base;
    logic [AW-1:0] r_sweep_idx, n_sweep_idx;
    logic        r_sweep_rst, n_sweep_rst;
    logic        r_out_valid, n_out_valid;

    logic [1:0]  r_op, n_op;
    logic [63:0] r_pay, n_pay;
    logic [3:0]  r_pb, n_pb;
    logic [8:0]  r_q, n_q;
    logic [AW-1:0] r_addr, n_addr;
    logic        r_half, n_half, r_fail, n_fail;
    logic [15:0] r_ptr, n_ptr;
    logic [12:0] r_left, n_left;
    logic [63:0] r_src, n_src;
    logic [23:0] r_adv, n_adv;
    logic [1:0]  r_res_status, n_res_status;
    logic [63:0] r_res_rdata, n_res_rdata;
    logic [3:0]  r_res_rbytes, n_res_rbytes;
    logic        r_res_last, n_res_last, r_res_wv, n_res_wv;
    logic [31:0] r_res_wg, n_res_wg;
    logic [1:0]  r_out_status, n_out_status;
    logic [63:0] r_out_rdata, n_out_rdata;
    logic [3:0]  r_out_rbytes, n_out_rbytes;
    logic        r_out_last, n_out_last, r_out_wv, n_out_wv;
    logic [31:0] r_out_wg, n_out_wg, r_out_gen, n_out_gen;

    t_store_wr     w_wr;
    t_store_rd     w_rd;
    logic [AW-1:0] w_addr;

    tmle_store #(
        .WORDS (MEMORY_WORDS),
        .SB    (STAMP_BITS)
    ) u_store (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .i_wr   (w_wr),
        .o_rd   (w_rd)
    );

    logic        w_is_rd;
    logic [15:0] w_copy_t, w_gt_t, w_nt_t;
    logic [3:0]  w_copy;
    logic [1:0]  w_nt;
    logic        w_gt_full;
    logic        w_swap;
    logic [12:0] w_group;
    logic [23:0] w_dst, w_low;
    logic [7:0]  w_cmask, w_smask;
    logic [63:0] w_spay, w_sold, w_cmask64;
    logic        w_slot_hi;
    logic [7:0]  w_rg_mask;
    logic [63:0] w_rg_data, w_rg_read;
    logic [2:0]  w_pos;
    logic [3:0]  w_room, w_segn;
    logic [7:0]  w_segmask;
    logic [63:0] w_segdata;
    logic [15:0] w_ptr_nx, w_sb16;
    logic [12:0] w_left_nx;
    logic [3:0]  w_pbc, w_pn;
    logic [12:0] w_prem;
    logic [13:0] w_per_row, w_unit_nx, w_row_nx;
    logic [12:0] w_rows;
    logic        w_row_end, w_all_end;
    logic [12:0] w_rcm1;
    logic [23:0] w_mul;
    logic [1:0]  w_chk;
    logic [23:0] w_f, w_ln, w_rw8, w_rw4, w_lim, w_rw, w_rc24, w_rl24, w_sb24;
    logic [STAMP_BITS-1:0] w_gen_nx;
    logic        w_adv;

    assign w_is_rd   = (r_mode == MODE_RD_TILE) || (r_mode == MODE_RD_RGBA);
    assign w_copy_t  = 16'(r_rl) - (16'(r_unit) << 3);
    assign w_copy    = (w_copy_t > 16'd8) ? 4'd8 : w_copy_t[3:0];
    assign w_group   = r_unit >> 1;
    assign w_gt_t    = 16'(r_rl) - (16'(w_group) << 2);
    assign w_gt_full = w_gt_t >= 16'd4;
    assign w_nt_t    = 16'(r_rl) - (16'(r_unit) << 1);
    assign w_nt      = (w_nt_t >= 16'd2) ? 2'd2 : w_nt_t[1:0];
    assign w_swap    = (r_mode == MODE_BLOCK) ? ((r_dxt != 12'd0) && r_acc[11]) : r_row[0];
    assign w_dst     = ((r_mode == MODE_TILE) || (r_mode == MODE_RD_TILE)) ?
                       24'(r_first) + r_row_base + 24'(r_unit) :
                       24'(r_first) + 24'(r_unit);
    assign w_low     = 24'(r_first) + r_row_base + 24'(w_group);
    assign w_cmask   = 8'((9'd1 << w_copy) - 9'd1);
    assign w_smask   = w_swap ? {w_cmask[3:0], w_cmask[7:4]} : w_cmask;
    assign w_spay    = w_swap ? {r_pay[31:0], r_pay[63:32]} : r_pay;
    assign w_sold    = w_swap ? {w_rd.data[31:0], w_rd.data[63:32]} : w_rd.data;
    assign w_slot_hi = r_unit[0] ^ r_row[0];

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_cmask64[8*b +: 8] = {8{w_cmask[b]}};
        end
    end

    always_comb begin
        w_rg_mask = '0;
        w_rg_data = '0;
        w_rg_read = '0;
        for (int k = 0; k < 2; k++) begin
            if (2'(k) < w_nt) begin
                w_rg_mask[{w_slot_hi, k[0], 1'b0} +: 2] = 2'b11;
                w_rg_data[{w_slot_hi, k[0], 4'd0} +: 16] =
                    r_pay[32*k + 16*int'(r_half) +: 16];
                w_rg_read[32*k + 16*int'(r_half) +: 16] =
                    w_rd.data[{w_slot_hi, k[0], 4'd0} +: 16];
            end
        end
    end

    assign w_pos     = r_ptr[2:0];
    assign w_room    = 4'd8 - 4'(w_pos);
    assign w_segn    = (13'(w_room) < r_left) ? w_room : r_left[3:0];
    assign w_segmask = 8'(((16'd1 << w_segn) - 16'd1) << w_pos);
    assign w_segdata = r_src << {w_pos, 3'd0};
    assign w_ptr_nx  = r_ptr + 16'(w_segn);
    assign w_left_nx = r_left - 13'(w_segn);
    assign w_sb16    = 16'(r_sb);
    assign w_pbc     = (r_pb > 4'd8) ? 4'd8 : r_pb;
    assign w_prem    = r_rl - r_unit;
    assign w_pn      = (13'(w_pbc) > w_prem) ? w_prem[3:0] : w_pbc;

    always_comb begin
        unique case (r_mode)
            MODE_RGBA, MODE_RD_RGBA: w_per_row = (14'(r_rl) + 14'd1) >> 1;
            MODE_TLUT:               w_per_row = 14'(r_rc);
            default:                 w_per_row = (14'(r_rl) + 14'd7) >> 3;
        endcase
        w_rows = ((r_mode == MODE_BLOCK) || (r_mode == MODE_TLUT)) ? 13'd1 : r_rc;
    end
    assign w_unit_nx = 14'(r_unit) + 14'd1;
    assign w_row_nx  = 14'(r_row) + 14'd1;
    assign w_row_end = w_unit_nx >= w_per_row;
    assign w_all_end = w_row_end && (w_row_nx >= 14'(w_rows));

    assign w_rcm1 = r_rc - 13'd1;
    assign w_mul  = 24'(w_rcm1) * 24'(r_line);
    assign w_f    = 24'(r_first);
    assign w_ln   = 24'(r_line);
    assign w_rc24 = 24'(r_rc);
    assign w_rl24 = 24'(r_rl);
    assign w_sb24 = 24'(r_sb);
    assign w_rw8  = (w_rl24 + 24'd7) >> 3;
    assign w_rw4  = (w_rl24 + 24'd3) >> 2;
    assign w_lim  = ((r_mode == MODE_RGBA) || (r_mode == MODE_RD_RGBA)) ? L_HALF : L_WORDS;
    assign w_rw   = ((r_mode == MODE_RGBA) || (r_mode == MODE_RD_RGBA)) ? w_rw4 : w_rw8;

    always_comb begin
        unique case (r_mode)
            MODE_TILE, MODE_RD_TILE, MODE_RGBA, MODE_RD_RGBA: begin
                priority if (r_rl == 13'd0 || r_rc == 13'd0) w_chk = CHK_EMPTY;
                else if (w_f > w_lim || w_rw > w_lim) w_chk = CHK_REJECT;
                else if (r_rc > 13'd1 && (w_ln == 24'd0 || w_rw > w_ln)) w_chk = CHK_REJECT;
                else if (r_adv > w_lim - w_f) w_chk = CHK_REJECT;
                else if (w_rw > w_lim - (w_f + r_adv)) w_chk = CHK_REJECT;
                else w_chk = CHK_WORK;
            end
            MODE_BLOCK: begin
                priority if (w_f > L_WORDS) w_chk = CHK_REJECT;
                else if (r_rl == 13'd0) w_chk = CHK_EMPTY;
                else if (w_rw8 > L_WORDS - w_f) w_chk = CHK_REJECT;
                else w_chk = CHK_WORK;
            end
            MODE_TLUT: begin
                priority if (w_f > L_WORDS || w_rc24 > L_WORDS - w_f) w_chk = CHK_REJECT;
                else if (r_rc == 13'd0) w_chk = CHK_EMPTY;
                else w_chk = CHK_WORK;
            end
            default: begin
                priority if (w_sb24 > L_BYTES || w_rl24 > L_BYTES - w_sb24) w_chk = CHK_REJECT;
                else if (r_rl == 13'd0) w_chk = CHK_EMPTY;
                else w_chk = CHK_WORK;
            end
        endcase
    end

    assign w_gen_nx = r_gen + STAMP_BITS'(1);

    always_comb begin
        n_state = r_state; n_mode = r_mode; n_first = r_first; n_line = r_line;
        n_rl = r_rl; n_rc = r_rc; n_sb = r_sb; n_dxt = r_dxt; n_gen = r_gen;
        n_active = r_active; n_row = r_row; n_unit = r_unit; n_acc = r_acc;
        n_row_base = r_row_base; n_sweep_idx = r_sweep_idx; n_sweep_rst = r_sweep_rst;
        n_out_valid = r_out_valid && !i_out_ready;
        n_op = r_op; n_pay = r_pay; n_pb = r_pb; n_q = r_q; n_addr = r_addr;
        n_half = r_half; n_fail = r_fail; n_ptr = r_ptr; n_left = r_left;
        n_src = r_src; n_adv = r_adv;
        n_res_status = r_res_status; n_res_rdata = r_res_rdata;
        n_res_rbytes = r_res_rbytes; n_res_last = r_res_last;
        n_res_wv = r_res_wv; n_res_wg = r_res_wg;
        n_out_status = r_out_status; n_out_rdata = r_out_rdata;
        n_out_rbytes = r_out_rbytes; n_out_last = r_out_last;
        n_out_wv = r_out_wv; n_out_wg = r_out_wg; n_out_gen = r_out_gen;
        w_addr = r_addr;
        w_wr = '0;
        w_wr.stamp = 32'(r_gen);
        w_adv = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_addr = r_sweep_idx;
                w_wr.stamp_we = 1'b1;
                w_wr.stamp = '0;
                w_wr.valid_we = r_sweep_rst;
                w_wr.valid = '0;
                if (r_sweep_idx == LAST_IDX) begin
                    n_state = r_sweep_rst ? S_IDLE : S_GO;
                    n_sweep_rst = 1'b0;
                end else begin
                    n_sweep_idx = r_sweep_idx + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_opcode; n_pay = i_payload; n_pb = i_payload_bytes;
                    n_q = i_query_word;
                    n_res_status = ST_OK; n_res_rdata = '0; n_res_rbytes = '0;
                    n_res_last = 1'b0; n_res_wv = 1'b0; n_res_wg = '0;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_op == OP_START) begin
                    n_active = 1'b0; n_row = '0; n_unit = '0; n_acc = '0;
                    n_row_base = '0;
                    n_state = S_CHK1;
                end else if (r_op == OP_QUERY) begin
                    n_addr = AW'(r_q);
                    n_state = (24'(r_q) < L_WORDS) ? S_RD : S_DONE;
                end else if (!r_active || ((r_op == OP_DATA) == w_is_rd) ||
                             r_mode == MODE_INVAL) begin
                    n_res_status = ST_NOXFER;
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                    n_half = 1'b0;
                    n_fail = 1'b0;
                    unique case (r_mode)
                        MODE_RGBA, MODE_RD_RGBA: n_addr = w_low[AW-1:0];
                        MODE_PHYS: begin
                            n_ptr = w_sb16 + 16'(r_unit);
                            n_left = 13'(w_pn);
                            n_src = r_pay;
                            n_addr = n_ptr[AW+2:3];
                            if (w_pn == 4'd0) n_state = S_DONE;
                        end
                        default: n_addr = w_dst[AW-1:0];
                    endcase
                end
            end
            S_CHK1: begin
                n_adv = w_mul;
                n_state = S_CHK2;
            end
            S_CHK2: begin
                unique case (w_chk)
                    CHK_REJECT: begin
                        n_res_status = ST_REJECT;
                        n_state = S_DONE;
                    end
                    CHK_EMPTY: begin
                        n_res_last = 1'b1;
                        n_state = S_DONE;
                    end
                    default: begin
                        if (w_is_rd) begin
                            n_active = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_BUMP;
                        end
                    end
                endcase
            end
            S_BUMP: begin
                if (w_gen_nx == '0) begin
                    n_gen = STAMP_BITS'(1);
                    n_sweep_idx = '0;
                    n_sweep_rst = 1'b0;
                    n_state = S_CLEAR;
                end else begin
                    n_gen = w_gen_nx;
                    n_state = S_GO;
                end
            end
            S_GO: begin
                if (r_mode == MODE_INVAL) begin
                    n_ptr = w_sb16;
                    n_left = r_rl;
                    n_addr = w_sb16[AW+2:3];
                    n_state = S_RD;
                end else begin
                    n_active = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                n_state = S_DONE;
                if (r_op == OP_QUERY) begin
                    n_res_wv = (w_rd.valid == 8'hFF);
                    n_res_wg = w_rd.stamp;
                end else begin
                    unique case (r_mode)
                        MODE_TILE, MODE_BLOCK: begin
                            w_wr.data_en = w_smask;
                            w_wr.data = w_spay;
                            w_wr.valid_we = 1'b1;
                            w_wr.valid = ((w_copy < 4'd8) ? 8'h00 : w_rd.valid) | w_smask;
                            w_wr.stamp_we = 1'b1;
                            if (r_mode == MODE_BLOCK) n_acc = r_acc + 24'(r_dxt);
                            w_adv = 1'b1;
                        end
                        MODE_RD_TILE: begin
                            if ((w_rd.valid & w_smask) != w_smask) begin
                                n_res_status = ST_BADREAD;
                                n_active = 1'b0;
                            end else begin
                                n_res_rdata = w_sold & w_cmask64;
                                n_res_rbytes = w_copy;
                                w_adv = 1'b1;
                            end
                        end
                        MODE_RGBA: begin
                            w_wr.data_en = w_rg_mask;
                            w_wr.data = w_rg_data;
                            w_wr.valid_we = 1'b1;
                            w_wr.valid = ((!r_unit[0] && !w_gt_full) ? 8'h00 : w_rd.valid)
                                         | w_rg_mask;
                            w_wr.stamp_we = 1'b1;
                            if (!r_half) begin
                                n_half = 1'b1;
                                n_addr = r_addr + HALF_IDX;
                                n_state = S_RD;
                            end else begin
                                w_adv = 1'b1;
                            end
                        end
                        MODE_RD_RGBA: begin
                            n_fail = r_fail || ((w_rd.valid & w_rg_mask) != w_rg_mask);
                            n_res_rdata = r_res_rdata | w_rg_read;
                            if (!r_half) begin
                                n_half = 1'b1;
                                n_addr = r_addr + HALF_IDX;
                                n_state = S_RD;
                            end else if (n_fail) begin
                                n_res_status = ST_BADREAD;
                                n_res_rdata = '0;
                                n_active = 1'b0;
                            end else begin
                                n_res_rbytes = {w_nt, 2'b00};
                                w_adv = 1'b1;
                            end
                        end
                        MODE_TLUT: begin
                            w_wr.data_en = 8'hFF;
                            w_wr.data = {4{r_pay[7:0], r_pay[15:8]}};
                            w_wr.valid_we = 1'b1;
                            w_wr.valid = 8'hFF;
                            w_wr.stamp_we = 1'b1;
                            w_adv = 1'b1;
                        end
                        default: begin
                            w_wr.stamp_we = 1'b1;
                            w_wr.valid_we = 1'b1;
                            if (r_mode == MODE_PHYS) begin
                                w_wr.data_en = w_segmask;
                                w_wr.data = w_segdata;
                                w_wr.valid = w_rd.valid | w_segmask;
                            end else begin
                                w_wr.valid = w_rd.valid & ~w_segmask;
                            end
                            n_ptr = w_ptr_nx;
                            n_left = w_left_nx;
                            n_src = r_src >> {w_segn, 3'd0};
                            if (w_left_nx == 13'd0) begin
                                if (r_mode == MODE_PHYS) begin
                                    n_unit = 13'(w_ptr_nx - w_sb16);
                                    if (n_unit >= r_rl) begin
                                        n_active = 1'b0;
                                        n_res_last = 1'b1;
                                    end
                                end else begin
                                    n_res_last = 1'b1;
                                end
                            end else begin
                                n_addr = w_ptr_nx[AW+2:3];
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_status = r_res_status; n_out_rdata = r_res_rdata;
                    n_out_rbytes = r_res_rbytes; n_out_last = r_res_last;
                    n_out_wv = r_res_wv; n_out_wg = r_res_wg;
                    n_out_gen = 32'(r_gen);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_adv) begin
            if (w_row_end) begin
                n_unit = '0;
                n_row = w_row_nx[12:0];
                n_row_base = r_row_base + 24'(r_line);
                if (w_all_end) begin
                    n_active = 1'b0;
                    n_res_last = 1'b1;
                end
            end else begin
                n_unit = w_unit_nx[12:0];
            end
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:       begin n_mode = t_mode'(i_cfg_data[2:0]); n_active = 1'b0; end
                CFG_FIRST_WORD: begin n_first = i_cfg_data[9:0]; n_active = 1'b0; end
                CFG_LINE_WORDS: begin n_line = i_cfg_data[9:0]; n_active = 1'b0; end
                CFG_ROW_LENGTH: begin n_rl = i_cfg_data; n_active = 1'b0; end
                CFG_ROW_COUNT:  begin n_rc = i_cfg_data; n_active = 1'b0; end
                CFG_DXT_STEP:   begin n_dxt = i_cfg_data[11:0]; n_active = 1'b0; end
                CFG_START_BYTE: begin n_sb = i_cfg_data; n_active = 1'b0; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_mode <= MODE_TILE; r_first <= '0; r_line <= '0;
            r_rl <= '0; r_rc <= '0; r_sb <= '0; r_dxt <= '0; r_gen <= '0;
            r_active <= 1'b0; r_row <= '0; r_unit <= '0; r_acc <= '0;
            r_row_base <= '0; r_sweep_idx <= '0; r_sweep_rst <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_mode <= n_mode; r_first <= n_first; r_line <= n_line;
            r_rl <= n_rl; r_rc <= n_rc; r_sb <= n_sb; r_dxt <= n_dxt; r_gen <= n_gen;
            r_active <= n_active; r_row <= n_row; r_unit <= n_unit; r_acc <= n_acc;
            r_row_base <= n_row_base; r_sweep_idx <= n_sweep_idx;
            r_sweep_rst <= n_sweep_rst; r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_pay <= n_pay; r_pb <= n_pb; r_q <= n_q; r_addr <= n_addr;
        r_half <= n_half; r_fail <= n_fail; r_ptr <= n_ptr; r_left <= n_left;
        r_src <= n_src; r_adv <= n_adv;
        r_res_status <= n_res_status; r_res_rdata <= n_res_rdata;
        r_res_rbytes <= n_res_rbytes; r_res_last <= n_res_last;
        r_res_wv <= n_res_wv; r_res_wg <= n_res_wg;
        r_out_status <= n_out_status; r_out_rdata <= n_out_rdata;
        r_out_rbytes <= n_out_rbytes; r_out_last <= n_out_last;
        r_out_wv <= n_out_wv; r_out_wg <= n_out_wg; r_out_gen <= n_out_gen;
    end

    assign o_in_ready            = (r_state == S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out_status;
    assign o_read_data           = r_out_rdata;
    assign o_read_bytes          = r_out_rbytes;
    assign o_last_unit           = r_out_last;
    assign o_word_is_valid       = r_out_wv;
    assign o_word_generation_out = r_out_wg;
    assign o_current_generation  = r_out_gen;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");
    a_no_ready_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("ready during clearing pass");
    a_inval_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_mode != MODE_INVAL))
        else $error("invalidate left a transfer running");
    a_bad_read_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == ST_BADREAD) |-> !r_active)
        else $error("transfer still active after bad read");
    a_read_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_read_bytes <= 4'd8))
        else $error("read byte count out of range");
`endif

endmodule

[sim/tmle_checker.sv]
`timescale 1ns / 1ps

module tmle_checker import tmle_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_payload,
    input  logic [3:0]  i_payload_bytes,
    input  logic [8:0]  i_query_word,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [63:0] i_read_data,
    input  logic [3:0]  i_read_bytes,
    input  logic        i_last_unit,
    input  logic        i_word_is_valid,
    input  logic [31:0] i_word_generation_out,
    input  logic [31:0] i_current_generation,
    output int          o_errors,
    output int          o_pending
);

    localparam int unsigned WORDS = 512;
    localparam int unsigned HALF = WORDS / 2;
    localparam int unsigned BYTES = WORDS * 8;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] rdata;
        logic [3:0]  rbytes;
        logic        last;
        logic        wv;
        logic [31:0] wg;
        logic [31:0] gen;
    } t_result;

    logic [63:0] tex_data [WORDS];
    logic [7:0]  tex_vld [WORDS];
    logic [31:0] tex_stamp [WORDS];
    logic [31:0] gen_cnt;
    bit          xfer_on;
    int unsigned row_c, unit_c;
    logic [23:0] dxt_acc;
    int unsigned r_mode, r_first, r_line, r_rlen, r_rows, r_dxt, r_sbyte;

    t_result results_due[$];

    assign o_pending = results_due.size();

    function automatic void put_byte(int unsigned w, int unsigned pos, logic [7:0] v);
        if (w < WORDS) begin
            tex_data[w][(pos % 8) * 8 +: 8] = v;
            tex_vld[w][pos % 8] = 1'b1;
        end
    endfunction

    function automatic bit fetch_byte(int unsigned w, int unsigned pos, output logic [7:0] v);
        v = 8'h00;
        if (w >= WORDS || !tex_vld[w][pos % 8]) return 1'b0;
        v = tex_data[w][(pos % 8) * 8 +: 8];
        return 1'b1;
    endfunction

    function automatic void stamp(int unsigned w);
        if (w < WORDS) tex_stamp[w] = gen_cnt;
    endfunction

    function automatic void clear_vld(int unsigned w);
        if (w < WORDS) tex_vld[w] = 8'h00;
    endfunction

    function automatic void bump_gen();
        logic [31:0] nxt;
        nxt = gen_cnt + 32'd1;
        if (nxt == 32'd0) begin
            nxt = 32'd1;
            foreach (tex_stamp[i]) tex_stamp[i] = 32'd0;
        end
        gen_cnt = nxt;
    endfunction

    function automatic bit tile_fits(int unsigned first, int unsigned line, int unsigned rw,
                                     int unsigned rows, int unsigned lim);
        int unsigned adv;
        if (first > lim || rw > lim) return 1'b0;
        if (rows == 0 || rw == 0) return 1'b1;
        if (rows > 1 && (line == 0 || rw > line)) return 1'b0;
        adv = (rows - 1) * line;
        if (adv > lim - first) return 1'b0;
        return rw <= lim - (first + adv);
    endfunction

    function automatic bit step_unit(int unsigned per_row, int unsigned rows);
        unit_c++;
        if (unit_c >= per_row) begin
            unit_c = 0;
            row_c++;
            if (row_c >= rows) begin
                xfer_on = 1'b0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [1:0] judge_descriptor();
        case (r_mode)
            MODE_TILE, MODE_RD_TILE: begin
                if (r_rlen == 0 || r_rows == 0) return CHK_EMPTY;
                return tile_fits(r_first, r_line, (r_rlen + 7) / 8, r_rows, WORDS)
                    ? CHK_WORK : CHK_REJECT;
            end
            MODE_RGBA, MODE_RD_RGBA: begin
                if (r_rlen == 0 || r_rows == 0) return CHK_EMPTY;
                return tile_fits(r_first, r_line, (r_rlen + 3) / 4, r_rows, HALF)
                    ? CHK_WORK : CHK_REJECT;
            end
            MODE_BLOCK: begin
                if (r_dxt > 12'hfff || r_first > WORDS) return CHK_REJECT;
                if (r_rlen == 0) return CHK_EMPTY;
                return ((r_rlen + 7) / 8 > WORDS - r_first) ? CHK_REJECT : CHK_WORK;
            end
            MODE_TLUT: begin
                if (r_first > WORDS || r_rows > WORDS - r_first) return CHK_REJECT;
                return r_rows == 0 ? CHK_EMPTY : CHK_WORK;
            end
            default: begin
                if (r_sbyte > BYTES || r_rlen > BYTES - r_sbyte) return CHK_REJECT;
                return r_rlen == 0 ? CHK_EMPTY : CHK_WORK;
            end
        endcase
    endfunction

    function automatic t_result predict_word(logic [1:0] op, logic [63:0] p,
                                             logic [3:0] pb, logic [8:0] q);
        t_result r;
        int unsigned row, unit, copy, dst, grp, gt, n, low, high, lane, mp, a, w, rem;
        bit odd, swap, is_read;
        logic [7:0] b0, b1, b2, b3;
        logic [1:0] verdict;
        r = '0;
        row = row_c;
        unit = unit_c;
        odd = row[0];
        is_read = (r_mode == MODE_RD_TILE || r_mode == MODE_RD_RGBA);
        if (op == OP_START) begin
            xfer_on = 1'b0;
            row_c = 0;
            unit_c = 0;
            dxt_acc = '0;
            verdict = judge_descriptor();
            if (verdict == CHK_REJECT) begin
                r.status = ST_REJECT;
            end else if (verdict == CHK_EMPTY) begin
                r.last = 1'b1;
            end else begin
                if (!is_read) bump_gen();
                if (r_mode == MODE_INVAL) begin
                    for (int unsigned k = 0; k < r_rlen; k++) begin
                        a = r_sbyte + k;
                        w = a >> 3;
                        if (w < WORDS) tex_vld[w][a % 8] = 1'b0;
                        stamp(w);
                    end
                    r.last = 1'b1;
                end else begin
                    xfer_on = 1'b1;
                end
            end
        end else if (op == OP_QUERY) begin
            if (q < WORDS) begin
                r.wv = (tex_vld[q] == 8'hff);
                r.wg = tex_stamp[q];
            end
        end else if (!xfer_on || (op == OP_DATA) == is_read || r_mode == MODE_INVAL) begin
            r.status = ST_NOXFER;
        end else if (r_mode == MODE_TILE || r_mode == MODE_RD_TILE || r_mode == MODE_BLOCK) begin
            copy = r_rlen - unit * 8;
            if (copy > 8) copy = 8;
            if (r_mode == MODE_BLOCK) begin
                dst = r_first + unit;
                swap = (r_dxt != 0) && dxt_acc[11];
            end else begin
                dst = r_first + row * r_line + unit;
                swap = odd;
            end
            if (r_mode == MODE_RD_TILE) begin
                for (int unsigned i = 0; i < copy; i++) begin
                    if (!fetch_byte(dst, swap ? (i ^ 4) : i, b0)) begin
                        r.status = ST_BADREAD;
                        xfer_on = 1'b0;
                        r.rdata = '0;
                        break;
                    end
                    r.rdata[i * 8 +: 8] = b0;
                end
                if (r.status == ST_OK) begin
                    r.rbytes = copy;
                    r.last = step_unit((r_rlen + 7) / 8, r_rows);
                end
            end else begin
                if (copy < 8) clear_vld(dst);
                for (int unsigned i = 0; i < copy; i++)
                    put_byte(dst, swap ? (i ^ 4) : i, p[i * 8 +: 8]);
                stamp(dst);
                if (r_mode == MODE_BLOCK) begin
                    dxt_acc = dxt_acc + 24'(r_dxt);
                    r.last = step_unit((r_rlen + 7) / 8, 1);
                end else begin
                    r.last = step_unit((r_rlen + 7) / 8, r_rows);
                end
            end
        end else if (r_mode == MODE_RGBA || r_mode == MODE_RD_RGBA) begin
            grp = unit >> 1;
            gt = r_rlen - grp * 4;
            n = r_rlen - unit * 2;
            low = r_first + row * r_line + grp;
            high = low + HALF;
            if (gt > 4) gt = 4;
            if (n > 2) n = 2;
            if (r_mode == MODE_RGBA && unit[0] == 1'b0 && gt < 4) begin
                clear_vld(low);
                clear_vld(high);
            end
            for (int unsigned k = 0; k < n; k++) begin
                lane = (unit * 2 + k) % 4;
                mp = (odd ? (lane ^ 2) : lane) * 2;
                if (r_mode == MODE_RGBA) begin
                    put_byte(low, mp, p[32 * k +: 8]);
                    put_byte(low, mp + 1, p[32 * k + 8 +: 8]);
                    put_byte(high, mp, p[32 * k + 16 +: 8]);
                    put_byte(high, mp + 1, p[32 * k + 24 +: 8]);
                end else begin
                    if (!fetch_byte(low, mp, b0) || !fetch_byte(low, mp + 1, b1) ||
                        !fetch_byte(high, mp, b2) || !fetch_byte(high, mp + 1, b3)) begin
                        r.status = ST_BADREAD;
                        xfer_on = 1'b0;
                        r.rdata = '0;
                        break;
                    end
                    r.rdata[32 * k +: 32] = {b3, b2, b1, b0};
                end
            end
            if (r_mode == MODE_RGBA) begin
                stamp(low);
                stamp(high);
            end
            if (r.status == ST_OK) begin
                if (r_mode == MODE_RD_RGBA) r.rbytes = 4 * n;
                r.last = step_unit((r_rlen + 1) / 2, r_rows);
            end
        end else if (r_mode == MODE_TLUT) begin
            dst = r_first + unit;
            for (int unsigned c = 0; c < 4; c++) begin
                put_byte(dst, c * 2, p[15:8]);
                put_byte(dst, c * 2 + 1, p[7:0]);
            end
            stamp(dst);
            r.last = step_unit(r_rows, 1);
        end else begin
            n = (pb > 8) ? 8 : pb;
            rem = r_rlen - unit;
            if (n > rem) n = rem;
            for (int unsigned k = 0; k < n; k++) begin
                a = r_sbyte + unit + k;
                put_byte(a >> 3, a % 8, p[k * 8 +: 8]);
                stamp(a >> 3);
            end
            unit_c = unit + n;
            if (unit_c >= r_rlen) begin
                xfer_on = 1'b0;
                r.last = 1'b1;
            end
        end
        r.gen = gen_cnt;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            foreach (tex_data[i]) begin
                tex_data[i] = '0;
                tex_vld[i] = '0;
                tex_stamp[i] = '0;
            end
            gen_cnt = '0;
            xfer_on = 1'b0;
            row_c = 0;
            unit_c = 0;
            dxt_acc = '0;
            {r_mode, r_first, r_line, r_rlen, r_rows, r_dxt, r_sbyte} = '0;
            results_due.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:       r_mode = i_cfg_data[2:0];
                    CFG_FIRST_WORD: r_first = i_cfg_data[9:0];
                    CFG_LINE_WORDS: r_line = i_cfg_data[9:0];
                    CFG_ROW_LENGTH: r_rlen = i_cfg_data;
                    CFG_ROW_COUNT:  r_rows = i_cfg_data;
                    CFG_DXT_STEP:   r_dxt = i_cfg_data[11:0];
                    CFG_START_BYTE: r_sbyte = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= CFG_START_BYTE) xfer_on = 1'b0;
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(predict_word(i_opcode, i_payload, i_payload_bytes,
                                                   i_query_word));
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result word with no input word pending");
                    o_errors++;
                end else begin
                    exp_r = results_due.pop_front();
                    if (i_status !== exp_r.status) begin
                        $error("status exp %0h got %0h", exp_r.status, i_status);
                        o_errors++;
                    end
                    if (i_read_data !== exp_r.rdata) begin
                        $error("read_data exp %h got %h", exp_r.rdata, i_read_data);
                        o_errors++;
                    end
                    if (i_read_bytes !== exp_r.rbytes) begin
                        $error("read_bytes exp %0d got %0d", exp_r.rbytes, i_read_bytes);
                        o_errors++;
                    end
                    if (i_last_unit !== exp_r.last) begin
                        $error("last_unit exp %0b got %0b", exp_r.last, i_last_unit);
                        o_errors++;
                    end
                    if (i_word_is_valid !== exp_r.wv) begin
                        $error("word_is_valid exp %0b got %0b", exp_r.wv, i_word_is_valid);
                        o_errors++;
                    end
                    if (i_word_generation_out !== exp_r.wg) begin
                        $error("word_generation_out exp %0h got %0h", exp_r.wg,
                               i_word_generation_out);
                        o_errors++;
                    end
                    if (i_current_generation !== exp_r.gen) begin
                        $error("current_generation exp %0h got %0h", exp_r.gen,
                               i_current_generation);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

[sim/tb_texture_memory_load_engine.sv]
`timescale 1ns / 1ps

module tb_texture_memory_load_engine;
    import tmle_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [63:0] payload = '0;
    logic [3:0]  payload_bytes = '0;
    logic [8:0]  query_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [63:0] read_data;
    logic [3:0]  read_bytes;
    logic        last_unit;
    logic        word_is_valid;
    logic [31:0] word_generation_out;
    logic [31:0] current_generation;

    int errors, pending;
    int words_sent = 0;
    int idle_pct = 0, stall_pct = 0;
    logic hold_req = 1'b0, hold_done = 1'b0;
    int hold_left = 0;
    int watchdog = 0;

    always #5 clk = ~clk;

    texture_memory_load_engine dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_opcode(opcode), .i_payload(payload), .i_payload_bytes(payload_bytes),
        .i_query_word(query_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_status(status), .o_read_data(read_data), .o_read_bytes(read_bytes),
        .o_last_unit(last_unit), .o_word_is_valid(word_is_valid),
        .o_word_generation_out(word_generation_out),
        .o_current_generation(current_generation)
    );

    tmle_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_opcode(opcode), .i_payload(payload), .i_payload_bytes(payload_bytes),
        .i_query_word(query_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_status(status), .i_read_data(read_data), .i_read_bytes(read_bytes),
        .i_last_unit(last_unit), .i_word_is_valid(word_is_valid),
        .i_word_generation_out(word_generation_out),
        .i_current_generation(current_generation),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            watchdog <= 0;
        end else if (watchdog >= WATCHDOG_LIMIT) begin
            $display("texture_memory_load_engine: mismatch");
            $finish;
        end else begin
            watchdog <= watchdog + 1;
        end
    end

    task automatic send_word(logic [1:0] op, logic [63:0] p, logic [3:0] pb, logic [8:0] q);
        case ((words_sent / 120) % 5)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 78; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 78; end
            3: begin idle_pct = 20; stall_pct = 20; end
            default: begin idle_pct = 0; stall_pct = 0; end
        endcase
        if (words_sent > 300 && !hold_req) hold_req <= 1'b1;
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        payload <= p;
        payload_bytes <= pb;
        query_word <= q;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic run_transfer(t_mode mode, int fw, int lw, int rl, int rc, int dxt, int sb);
        int units, sum, pb;
        drain();
        write_reg(CFG_MODE, 13'(mode));
        write_reg(CFG_FIRST_WORD, 13'(fw));
        write_reg(CFG_LINE_WORDS, 13'(lw));
        write_reg(CFG_ROW_LENGTH, 13'(rl));
        write_reg(CFG_ROW_COUNT, 13'(rc));
        write_reg(CFG_DXT_STEP, 13'(dxt));
        write_reg(CFG_START_BYTE, 13'(sb));
        cfg_we <= 1'b0;
        send_word(OP_START, rand64(), 4'($urandom_range(8)), 9'($urandom_range(511)));
        case (mode)
            MODE_TILE, MODE_RD_TILE: units = ((rl + 7) / 8) * rc;
            MODE_RGBA, MODE_RD_RGBA: units = ((rl + 1) / 2) * rc;
            MODE_BLOCK: units = (rl + 7) / 8;
            MODE_TLUT: units = rc;
            MODE_PHYS: units = rl;
            default: units = 1;
        endcase
        if (units > 48) units = 48;
        sum = 0;
        for (int u = 0; u < units && (mode != MODE_PHYS || sum < rl); u++) begin
            if ($urandom_range(99) < 5) begin
                send_word($urandom_range(1) ? OP_QUERY : OP_DATA, rand64(),
                          4'($urandom_range(8)), 9'($urandom_range(511)));
            end
            pb = ($urandom_range(3) == 0) ? $urandom_range(8) : 8;
            sum += pb;
            send_word((mode == MODE_RD_TILE || mode == MODE_RD_RGBA) ? OP_READ : OP_DATA,
                      rand64(), 4'(pb), 9'($urandom_range(511)));
        end
        for (int k = 0; k < 2; k++)
            send_word(OP_QUERY, rand64(), 4'($urandom_range(8)), 9'(fw + k));
    endtask

    initial begin
        t_mode md;
        int fw, lw, rl, rc;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_word(OP_QUERY, '0, 4'd0, 9'd0);
        send_word(OP_QUERY, '1, 4'd8, 9'd511);
        send_word(OP_DATA, '1, 4'd8, 9'd0);
        run_transfer(MODE_TILE, 0, 2, 12, 2, 0, 0);
        run_transfer(MODE_RD_TILE, 0, 2, 12, 2, 0, 0);
        run_transfer(MODE_RGBA, 3, 1, 3, 2, 0, 0);
        run_transfer(MODE_RD_RGBA, 3, 1, 3, 2, 0, 0);
        run_transfer(MODE_BLOCK, 20, 0, 20, 0, 2048, 0);
        run_transfer(MODE_BLOCK, 40, 0, 8, 0, 4095, 0);
        run_transfer(MODE_TLUT, 30, 0, 0, 2, 0, 0);
        run_transfer(MODE_PHYS, 0, 0, 10, 0, 0, 7);
        run_transfer(MODE_INVAL, 0, 0, 16, 0, 0, 0);
        run_transfer(MODE_RD_TILE, 0, 2, 12, 2, 0, 0);
        run_transfer(MODE_TILE, 512, 512, 4096, 4096, 0, 0);
        run_transfer(MODE_PHYS, 0, 0, 0, 0, 0, 4096);
        run_transfer(MODE_TILE, 0, 0, 0, 0, 0, 0);

        while (words_sent < 620) begin
            md = t_mode'($urandom_range(7));
            fw = ($urandom_range(9) == 0) ? $urandom_range(512) : $urandom_range(60);
            lw = ($urandom_range(9) == 0) ? $urandom_range(512) : $urandom_range(1, 6);
            rl = ($urandom_range(19) == 0) ? $urandom_range(4096) : $urandom_range(1, 24);
            rc = ($urandom_range(19) == 0) ? $urandom_range(4096) : $urandom_range(1, 4);
            run_transfer(md, fw, lw, rl, rc, $urandom_range(4095),
                         ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(200));
            if (md == MODE_TILE || md == MODE_RGBA)
                run_transfer(md == MODE_TILE ? MODE_RD_TILE : MODE_RD_RGBA, fw, lw, rl, rc, 0, 0);
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("texture_memory_load_engine: match");
        else
            $display("texture_memory_load_engine: mismatch");
        $finish;
    end

endmodule

[sim.f]
hdl/tmle_pkg.sv
hdl/tmle_store.sv
hdl/texture_memory_load_engine.sv
sim/tmle_checker.sv
sim/tb_texture_memory_load_engine.sv
